>>> rtl/core/tlvp_pkg.sv
// Shared types and constants for the TLV item body parser.
// Holds the parse phase enum, role codes, id thresholds and the result struct.
// No dependencies.
package tlvp_pkg;

  typedef enum logic [2:0] {
    PH_COUNT  = 3'd0,
    PH_ID     = 3'd1,
    PH_VALUE  = 3'd2,
    PH_LENGTH = 3'd3,
    PH_BUFFER = 3'd4
  } phase_t;

  localparam logic [2:0] ROLE_COUNT  = 3'd0;
  localparam logic [2:0] ROLE_ID     = 3'd1;
  localparam logic [2:0] ROLE_VALUE  = 3'd2;
  localparam logic [2:0] ROLE_LENGTH = 3'd3;
  localparam logic [2:0] ROLE_BUFFER = 3'd4;

  // Ids at or above this, and below ID_BUFFER_MIN, carry one value byte.
  localparam logic [7:0] ID_VALUE_MIN  = 8'd50;
  // Ids at or above this carry a length byte and a buffer.
  localparam logic [7:0] ID_BUFFER_MIN = 8'd128;

  typedef struct packed {
    logic [2:0] role;
    logic [7:0] item_tag;
    logic [7:0] item_number;
    logic [7:0] byte_value;
    logic       item_done;
    logic       body_done;
  } result_t;

endpackage

>>> rtl/core/tlv_item_body_parser.sv
// A beat held in the input register is loaded into the result register, and shows on
//   out_tvalid, once that register is free.
// Throughput: one byte per cycle while results are taken; the phase and counter update is
//   combinational logic between the input register and the result register. A held result
//   (out_tready low) stalls the parser and then the input, with no bubble on release.
// Reset (rst_n low, synchronous): both stages empty, parser waits for a count byte.
// Depends on tlvp_pkg, tlvp_step and tlvp_out_reg.
module tlv_item_body_parser
  import tlvp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] body_byte
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] item_tag, [15:8] item_number, [23:16] byte_value
  output logic [3:0]  out_tuser,  // [2:0] role, [3] item_done
  output logic        out_tlast   // body_done
);

  // Input register stage.
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;

  logic       out_valid;
  logic       out_free;
  logic       advance;
  logic       in_fire;
  result_t    step_res;
  result_t    out_res;

  // The result slot can take a new beat when empty or being drained now.
  assign out_free  = !out_valid || out_tready;
  // Advance the held byte through the parser into the result register.
  assign advance   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_fire) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  // Payload: hold unless a new beat arrives.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_byte_r <= in_tdata;
    end
  end

  // Parser state only steps when its result is moved into the result register.
  tlvp_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .body_byte (in_byte_r),
    .res       (step_res)
  );

  tlvp_out_reg u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (advance),
    .res_in  (step_res),
    .take    (out_tready),
    .valid   (out_valid),
    .res_out (out_res)
  );

  assign out_tvalid = out_valid;
  assign out_tdata  = {out_res.byte_value, out_res.item_number, out_res.item_tag};
  assign out_tuser  = {out_res.item_done, out_res.role};
  assign out_tlast  = out_res.body_done;

`ifndef NO_ASSERTIONS
  // A count beat never closes an item and always carries tag and index zero.
  a_count_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2:0] == ROLE_COUNT |->
      !out_tuser[3] && out_tdata[15:0] == 16'd0)
    else $error("count beat carries item fields");

  // A body can only end inside an item on the same beat that closes the item.
  a_body_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && out_tuser[2:0] != ROLE_COUNT |-> out_tuser[3])
    else $error("body_done without item_done");

  // A value beat always closes its item.
  a_value_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2:0] == ROLE_VALUE |-> out_tuser[3])
    else $error("value beat did not close item");

  // An empty input register never stalls the source.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> in_tready)
    else $error("input stalled with empty register");

  // An advanced byte shows up as a valid result on the next edge.
  a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_tvalid)
    else $error("advanced beat lost");
`endif

endmodule

>>> rtl/core/tlvp_step.sv
// Parse state machine of the TLV item body parser: phase, counters, byte tagging.
// Depends on tlvp_pkg.
module tlvp_step
  import tlvp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] body_byte,
  output result_t    res
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] items_rem_r, items_rem_nxt;
  logic [7:0] buf_rem_r, buf_rem_nxt;
  logic [7:0] cur_tag_r, cur_tag_nxt;
  logic [7:0] item_pos_r, item_pos_nxt;

  logic [7:0] items_dec;
  logic [7:0] buf_dec;
  logic       body_last;

  assign items_dec = items_rem_r - 8'd1;
  assign buf_dec   = buf_rem_r - 8'd1;
  assign body_last = (items_dec == 8'd0);

  // Next state.
  always_comb begin
    phase_nxt     = phase_r;
    items_rem_nxt = items_rem_r;
    buf_rem_nxt   = buf_rem_r;
    cur_tag_nxt   = cur_tag_r;
    item_pos_nxt  = item_pos_r;
    case (phase_r)
      PH_ID: begin
        cur_tag_nxt = body_byte;
        if (body_byte < ID_VALUE_MIN) begin
          items_rem_nxt = items_dec;
          phase_nxt     = body_last ? PH_COUNT : PH_ID;
          item_pos_nxt  = body_last ? 8'd0 : item_pos_r + 8'd1;
        end else if (body_byte < ID_BUFFER_MIN) begin
          phase_nxt = PH_VALUE;
        end else begin
          phase_nxt = PH_LENGTH;
        end
      end
      PH_VALUE: begin
        items_rem_nxt = items_dec;
        phase_nxt     = body_last ? PH_COUNT : PH_ID;
        item_pos_nxt  = body_last ? 8'd0 : item_pos_r + 8'd1;
      end
      PH_LENGTH: begin
        if (body_byte == 8'd0) begin
          items_rem_nxt = items_dec;
          phase_nxt     = body_last ? PH_COUNT : PH_ID;
          item_pos_nxt  = body_last ? 8'd0 : item_pos_r + 8'd1;
        end else begin
          buf_rem_nxt = body_byte;
          phase_nxt   = PH_BUFFER;
        end
      end
      PH_BUFFER: begin
        buf_rem_nxt = buf_dec;
        if (buf_dec == 8'd0) begin
          items_rem_nxt = items_dec;
          phase_nxt     = body_last ? PH_COUNT : PH_ID;
          item_pos_nxt  = body_last ? 8'd0 : item_pos_r + 8'd1;
        end
      end
      default: begin
        cur_tag_nxt   = 8'd0;
        item_pos_nxt  = 8'd0;
        items_rem_nxt = body_byte;
        phase_nxt     = (body_byte == 8'd0) ? PH_COUNT : PH_ID;
      end
    endcase
  end

  // Outputs for the byte in hand.
  always_comb begin
    res.byte_value  = body_byte;
    res.item_number = item_pos_r;
    res.item_tag    = cur_tag_r;
    res.item_done   = 1'b0;
    res.body_done   = 1'b0;
    case (phase_r)
      PH_ID: begin
        res.role     = ROLE_ID;
        res.item_tag = body_byte;
        if (body_byte < ID_VALUE_MIN) begin
          res.item_done = 1'b1;
          res.body_done = body_last;
        end
      end
      PH_VALUE: begin
        res.role      = ROLE_VALUE;
        res.item_done = 1'b1;
        res.body_done = body_last;
      end
      PH_LENGTH: begin
        res.role = ROLE_LENGTH;
        if (body_byte == 8'd0) begin
          res.item_done = 1'b1;
          res.body_done = body_last;
        end
      end
      PH_BUFFER: begin
        res.role = ROLE_BUFFER;
        if (buf_dec == 8'd0) begin
          res.item_done = 1'b1;
          res.body_done = body_last;
        end
      end
      default: begin
        res.role        = ROLE_COUNT;
        res.item_tag    = 8'd0;
        res.item_number = 8'd0;
        res.body_done   = (body_byte == 8'd0);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_COUNT;
      items_rem_r <= 8'd0;
      buf_rem_r   <= 8'd0;
      cur_tag_r   <= 8'd0;
      item_pos_r  <= 8'd0;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      items_rem_r <= items_rem_nxt;
      buf_rem_r   <= buf_rem_nxt;
      cur_tag_r   <= cur_tag_nxt;
      item_pos_r  <= item_pos_nxt;
    end
  end

endmodule

>>> rtl/core/tlvp_out_reg.sv
// Result register of the TLV item body parser: holds one tagged beat for the sink.
// Depends on tlvp_pkg.
module tlvp_out_reg
  import tlvp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res_in,
  input  logic    take,
  output logic    valid,
  output result_t res_out
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign valid   = valid_r;
  assign res_out = res_r;

endmodule
